// ----- design/alm_pkg.sv -----
package alm_pkg;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int COUNT_BITS      = 12;
  localparam int FINE_BITS       = 8;
  localparam int COARSE_BITS     = COUNT_BITS - FINE_BITS;
  localparam int FINE_DEPTH      = 1 << FINE_BITS;
  localparam int COARSE_DEPTH    = 1 << COARSE_BITS;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 17;
  localparam int CFG_TIME_W      = 16;

  localparam int Q30_FRAC   = 30;
  localparam int Q30_W      = Q30_FRAC + 1;
  localparam int Q30_PROD_W = 2 * Q30_FRAC + 1;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [Q30_W-1:0]   Q30_ONE    = {1'b1, {Q30_FRAC{1'b0}}};
  localparam logic [Q30_W-1:0]   Q30_HALF   = {2'b01, {(Q30_FRAC - 1){1'b0}}};

  localparam logic [63:0] ROM_ONE     = 64'd1073741824;
  localparam logic [63:0] ROM_HALF    = 64'd536870912;
  localparam logic [63:0] FINE_STEP   = 64'd1073300001;
  localparam logic [63:0] COARSE_STEP = 64'd966367642;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PEAK_DECAY      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HOLD_TIME       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_REDRAW_INTERVAL = 2'd2;

  localparam logic [LEVEL_W-1:0]    RST_PEAK_DECAY      = 17'd66;
  localparam logic [CFG_TIME_W-1:0] RST_HOLD_TIME       = 16'd2000;
  localparam logic [CFG_TIME_W-1:0] RST_REDRAW_INTERVAL = 16'd100;

  typedef enum logic [1:0] {
    OP_LEVEL = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_GAIN_GO,
    ST_GAIN,
    ST_RMS_OLD,
    ST_RMS_NEW,
    ST_DECAY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [LEVEL_W-1:0]    rms_in;
    logic [LEVEL_W-1:0]    peak_in;
    logic [COUNT_BITS-1:0] sample_count;
  } alm_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_out;
    logic [LEVEL_W-1:0] decayed_peak_out;
    logic [LEVEL_W-1:0] hold_out;
    logic               redraw;
  } alm_out_t;

  typedef logic [Q30_W-1:0] q30_t;
  typedef q30_t fine_rom_t [FINE_DEPTH];
  typedef q30_t coarse_rom_t [COARSE_DEPTH];

  function automatic fine_rom_t build_fine_rom();
    fine_rom_t   rom;
    logic [63:0] v;
    v = ROM_ONE;
    for (int i = 0; i < FINE_DEPTH; i++) begin
      rom[i] = v[Q30_W-1:0];
      v = (v * FINE_STEP + ROM_HALF) >> Q30_FRAC;
    end
    return rom;
  endfunction

  function automatic coarse_rom_t build_coarse_rom();
    coarse_rom_t rom;
    logic [63:0] v;
    v = ROM_ONE;
    for (int i = 0; i < COARSE_DEPTH; i++) begin
      rom[i] = v[Q30_W-1:0];
      v = (v * COARSE_STEP + ROM_HALF) >> Q30_FRAC;
    end
    return rom;
  endfunction

  localparam fine_rom_t   FINE_ROM   = build_fine_rom();
  localparam coarse_rom_t COARSE_ROM = build_coarse_rom();

endpackage

// ----- design/alm_gain_rom.sv -----
module alm_gain_rom
  import alm_pkg::*;
(
  input  logic                  clk,
  input  logic [COUNT_BITS-1:0] count,
  output q30_t                  coarse_q,
  output q30_t                  fine_q
);

  q30_t coarse_r;
  q30_t fine_r;

  always_ff @(posedge clk) begin
    coarse_r <= COARSE_ROM[count[COUNT_BITS-1:FINE_BITS]];
    fine_r   <= FINE_ROM[count[FINE_BITS-1:0]];
  end

  assign coarse_q = coarse_r;
  assign fine_q   = fine_r;

endmodule

// ----- design/alm_serial_mul.sv -----
module alm_serial_mul #(
  parameter int MC_W = 31,
  parameter int MP_W = 31,
  parameter int P_W  = 61
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [MC_W-1:0] mcand,
  input  logic [MP_W-1:0] mplr,
  input  logic [P_W-1:0]  acc_init,
  output logic            busy,
  output logic [P_W-1:0]  acc
);

  logic [P_W-1:0]  mc_r, mc_nxt;
  logic [MP_W-1:0] mp_r, mp_nxt;
  logic [P_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    mc_nxt  = mc_r;
    mp_nxt  = mp_r;
    acc_nxt = acc_r;
    if (start) begin
      mc_nxt  = P_W'(mcand);
      mp_nxt  = mplr;
      acc_nxt = acc_init;
    end else if (mp_r != '0) begin
      acc_nxt = acc_r + (mp_r[0] ? mc_r : '0);
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= '0;
    end else begin
      mp_r <= mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = (mp_r != '0);
  assign acc  = acc_r;

endmodule

// ----- design/audio_level_meter_ballistics.sv -----
// Level meter ballistics with peak hold.
// Input words arrive on in_valid/in_ready/in_word: a level update, a one
// millisecond tick or a clear. Every accepted word yields exactly one result
// word on out_valid/out_ready/out_word with the levels after that word.
// Registers are written on cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high, and writes are meant to land while no word is in flight.
// Words are processed one at a time. In a level update a shift-and-add
// multiplier retires one multiplier bit per cycle over three passes (gain
// factor, old level, new level), and passes end early when the remaining
// multiplier bits are zero. A tick that runs the decay evaluation makes one
// multiplier pass for the decay product; other words skip the multiplier.
// The result sits in an output register, so the next word is taken and worked
// on while a result waits; a finished word then holds until out_ready frees
// that register. Reset is synchronous and active low; it zeroes all levels,
// timers and the redraw counter and loads the register defaults.
module audio_level_meter_ballistics
  import alm_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  alm_in_t                in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output alm_out_t               out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MC_W   = Q30_W;
  localparam int MP_W   = (TIMER_BITS > Q30_W) ? TIMER_BITS : Q30_W;
  localparam int P_W    = (Q30_PROD_W > LEVEL_W + TIMER_BITS) ? Q30_PROD_W
                                                              : LEVEL_W + TIMER_BITS;
  localparam int CMP_W  = (TIMER_BITS > CFG_TIME_W) ? TIMER_BITS : CFG_TIME_W;

  state_t state_r, state_nxt;

  logic [LEVEL_W-1:0]    peak_decay_r;
  logic [CFG_TIME_W-1:0] hold_time_r;
  logic [CFG_TIME_W-1:0] redraw_interval_r;

  logic [LEVEL_W-1:0]    rms_level_r, rms_level_nxt;
  logic [LEVEL_W-1:0]    latched_peak_r, latched_peak_nxt;
  logic [LEVEL_W-1:0]    decayed_peak_r, decayed_peak_nxt;
  logic [LEVEL_W-1:0]    hold_level_r, hold_level_nxt;
  logic [TIMER_BITS-1:0] ms_peak_r, ms_peak_nxt;
  logic [TIMER_BITS-1:0] ms_hold_r, ms_hold_nxt;
  logic [CFG_TIME_W-1:0] redraw_cnt_r, redraw_cnt_nxt;
  logic                  redraw_flag_r, redraw_flag_nxt;

  logic [LEVEL_W-1:0]    rms_in_r, rms_in_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  q30_t                  s_r, s_nxt;

  logic                  out_valid_r, out_valid_nxt;
  alm_out_t              out_word_r, out_word_nxt;

  logic                  mul_start;
  logic [MC_W-1:0]       mul_mcand;
  logic [MP_W-1:0]       mul_mplr;
  logic [P_W-1:0]        mul_init;
  logic                  mul_busy;
  logic [P_W-1:0]        mul_acc;

  q30_t                  coarse_q;
  q30_t                  fine_q;

  logic [LEVEL_W-1:0]    rms_clamp;
  logic [LEVEL_W-1:0]    peak_clamp;
  logic [LEVEL_W-1:0]    decay_clamp;
  logic [TIMER_BITS-1:0] ms_peak_inc;
  logic [TIMER_BITS-1:0] ms_hold_inc;
  logic [CFG_TIME_W-1:0] redraw_cnt_inc;
  logic [CFG_TIME_W-1:0] interval_eff;
  logic                  evaluate;
  q30_t                  s_acc;

  alm_gain_rom u_rom (
    .clk      (clk),
    .count    (count_r),
    .coarse_q (coarse_q),
    .fine_q   (fine_q)
  );

  alm_serial_mul #(
    .MC_W (MC_W),
    .MP_W (MP_W),
    .P_W  (P_W)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .mcand    (mul_mcand),
    .mplr     (mul_mplr),
    .acc_init (mul_init),
    .busy     (mul_busy),
    .acc      (mul_acc)
  );

  assign rms_clamp   = (in_word.rms_in > FULL_SCALE) ? FULL_SCALE : in_word.rms_in;
  assign peak_clamp  = (in_word.peak_in > FULL_SCALE) ? FULL_SCALE : in_word.peak_in;
  assign decay_clamp = (peak_decay_r > FULL_SCALE) ? FULL_SCALE : peak_decay_r;
  assign ms_peak_inc = (ms_peak_r == {TIMER_BITS{1'b1}}) ? ms_peak_r
                                                         : ms_peak_r + 1'b1;
  assign ms_hold_inc = (ms_hold_r == {TIMER_BITS{1'b1}}) ? ms_hold_r
                                                         : ms_hold_r + 1'b1;
  assign redraw_cnt_inc = redraw_cnt_r + 1'b1;
  assign interval_eff   = (redraw_interval_r == '0) ? CFG_TIME_W'(1) : redraw_interval_r;
  assign evaluate       = (redraw_cnt_inc >= interval_eff);
  assign s_acc          = mul_acc[Q30_FRAC +: Q30_W];

  always_comb begin
    state_nxt        = state_r;
    rms_level_nxt    = rms_level_r;
    latched_peak_nxt = latched_peak_r;
    decayed_peak_nxt = decayed_peak_r;
    hold_level_nxt   = hold_level_r;
    ms_peak_nxt      = ms_peak_r;
    ms_hold_nxt      = ms_hold_r;
    redraw_cnt_nxt   = redraw_cnt_r;
    redraw_flag_nxt  = redraw_flag_r;
    rms_in_nxt       = rms_in_r;
    count_nxt        = count_r;
    s_nxt            = s_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_word_nxt     = out_word_r;
    mul_start        = 1'b0;
    mul_mcand        = '0;
    mul_mplr         = '0;
    mul_init         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          redraw_flag_nxt = 1'b0;
          state_nxt       = ST_DONE;
          case (in_word.operation)
            OP_LEVEL: begin
              rms_in_nxt = rms_clamp;
              count_nxt  = in_word.sample_count;
              if (peak_clamp > decayed_peak_r) begin
                latched_peak_nxt = peak_clamp;
                decayed_peak_nxt = peak_clamp;
                ms_peak_nxt      = '0;
              end
              if (peak_clamp > hold_level_r) begin
                hold_level_nxt = peak_clamp;
                ms_hold_nxt    = '0;
              end
              state_nxt = ST_ROM;
            end
            OP_TICK: begin
              ms_peak_nxt    = ms_peak_inc;
              ms_hold_nxt    = ms_hold_inc;
              redraw_cnt_nxt = redraw_cnt_inc;
              if (evaluate) begin
                redraw_cnt_nxt  = '0;
                redraw_flag_nxt = 1'b1;
                if (CMP_W'(ms_hold_inc) > CMP_W'(hold_time_r)) begin
                  hold_level_nxt = '0;
                end
                mul_start = 1'b1;
                mul_mcand = MC_W'(decay_clamp);
                mul_mplr  = MP_W'(ms_peak_inc);
                mul_init  = '0;
                state_nxt = ST_DECAY;
              end
            end
            OP_CLEAR: begin
              rms_level_nxt    = '0;
              latched_peak_nxt = '0;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_ROM: begin
        state_nxt = ST_GAIN_GO;
      end
      ST_GAIN_GO: begin
        mul_start = 1'b1;
        mul_mcand = MC_W'(coarse_q);
        mul_mplr  = MP_W'(fine_q);
        mul_init  = P_W'(Q30_HALF);
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        if (!mul_busy) begin
          s_nxt     = s_acc;
          mul_start = 1'b1;
          mul_mcand = MC_W'(s_acc);
          mul_mplr  = MP_W'(rms_level_r);
          mul_init  = P_W'(Q30_HALF);
          state_nxt = ST_RMS_OLD;
        end
      end
      ST_RMS_OLD: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_mcand = MC_W'(Q30_ONE - s_r);
          mul_mplr  = MP_W'(rms_in_r);
          mul_init  = mul_acc;
          state_nxt = ST_RMS_NEW;
        end
      end
      ST_RMS_NEW: begin
        if (!mul_busy) begin
          rms_level_nxt = mul_acc[Q30_FRAC +: LEVEL_W];
          state_nxt     = ST_DONE;
        end
      end
      ST_DECAY: begin
        if (!mul_busy) begin
          if (mul_acc < P_W'(latched_peak_r)) begin
            decayed_peak_nxt = latched_peak_r - mul_acc[LEVEL_W-1:0];
          end else begin
            decayed_peak_nxt = '0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_word_nxt.rms_out          = rms_level_r;
          out_word_nxt.decayed_peak_out = decayed_peak_r;
          out_word_nxt.hold_out         = hold_level_r;
          out_word_nxt.redraw           = redraw_flag_r;
          state_nxt                     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      peak_decay_r      <= RST_PEAK_DECAY;
      hold_time_r       <= RST_HOLD_TIME;
      redraw_interval_r <= RST_REDRAW_INTERVAL;
      rms_level_r       <= '0;
      latched_peak_r    <= '0;
      decayed_peak_r    <= '0;
      hold_level_r      <= '0;
      ms_peak_r         <= '0;
      ms_hold_r         <= '0;
      redraw_cnt_r      <= '0;
      redraw_flag_r     <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rms_level_r    <= rms_level_nxt;
      latched_peak_r <= latched_peak_nxt;
      decayed_peak_r <= decayed_peak_nxt;
      hold_level_r   <= hold_level_nxt;
      ms_peak_r      <= ms_peak_nxt;
      ms_hold_r      <= ms_hold_nxt;
      redraw_cnt_r   <= redraw_cnt_nxt;
      redraw_flag_r  <= redraw_flag_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IDX_PEAK_DECAY:      peak_decay_r      <= cfg_data;
          CFG_IDX_HOLD_TIME:       hold_time_r       <= cfg_data[CFG_TIME_W-1:0];
          CFG_IDX_REDRAW_INTERVAL: redraw_interval_r <= cfg_data[CFG_TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rms_in_r   <= rms_in_nxt;
    count_r    <= count_nxt;
    s_r        <= s_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

endmodule
